// ===== design/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants for the router solicitation checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

    localparam int unsigned MacW = 48;

    localparam logic [7:0]  SOLICIT_TYPE = 8'd133;
    localparam logic [7:0]  OPT_SRC_LLA  = 8'd1;
    localparam logic [10:0] LLA_BYTES    = 11'd6;

    // verdict codes
    localparam logic [3:0] V_ACCEPT    = 4'd0;
    localparam logic [3:0] V_SHORT     = 4'd1;
    localparam logic [3:0] V_CODE      = 4'd2;
    localparam logic [3:0] V_TYPE      = 4'd3;
    localparam logic [3:0] V_ZERO_LEN  = 4'd4;
    localparam logic [3:0] V_DUPLICATE = 4'd5;
    localparam logic [3:0] V_SIZE      = 4'd6;
    localparam logic [3:0] V_TRUNC     = 4'd7;
    localparam logic [3:0] V_UNIDENT   = 4'd8;

    // configuration register index
    localparam logic REG_SKIP_CHECK = 1'b0;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OPT_TYPE,
        PH_OPT_LEN,
        PH_LLA,
        PH_SKIP,
        PH_DRAIN
    } t_phase;

    typedef struct packed {
        logic [3:0]      verdict;
        logic            mac_present;
        logic [MacW-1:0] mac;
    } t_result;

endpackage

`default_nettype wire

// ===== design/rsc_parser.sv =====
// ----------------------------------------------------------------------------
// rsc_parser
// Per-byte message parse state; gives the verdict of the byte being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire logic            i_unspec,
    input  wire logic            i_skip_check,
    output rsc_pkg::t_result     o_result
);
    import rsc_pkg::*;

    t_phase          r_phase, n_phase, w_phase;
    logic [2:0]      r_cnt, n_cnt, w_cnt;
    logic [10:0]     r_rem, n_rem, w_rem, w_dec;
    logic            r_lla, n_lla, w_lla;
    logic            r_seen, n_seen, w_seen;
    logic [MacW-1:0] r_mac, n_mac, w_mac;
    logic [3:0]      r_err, n_err, w_err;
    logic            r_unspec, n_unspec, w_unspec;
    logic [3:0]      w_verdict;

    always_comb begin
        w_phase  = r_phase;
        w_cnt    = r_cnt;
        w_rem    = r_rem;
        w_lla    = r_lla;
        w_seen   = r_seen;
        w_mac    = r_mac;
        w_err    = r_err;
        w_unspec = r_unspec;
        w_dec    = (r_rem != 11'd0) ? r_rem - 11'd1 : r_rem;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_cnt == 3'd0) begin
                    w_unspec = i_unspec;
                    if (!i_skip_check && i_byte != SOLICIT_TYPE) begin
                        w_err = V_TYPE;
                    end
                end else if (r_cnt == 3'd1) begin
                    if (!i_skip_check && i_byte != 8'd0) begin
                        w_err = V_CODE;
                    end
                end
                if (r_cnt == 3'd7) begin
                    w_phase = (w_err != V_ACCEPT) ? PH_DRAIN : PH_OPT_TYPE;
                end else begin
                    w_cnt = r_cnt + 3'd1;
                end
            end
            PH_OPT_TYPE: begin
                w_lla   = (i_byte == OPT_SRC_LLA);
                w_phase = PH_OPT_LEN;
            end
            PH_OPT_LEN: begin
                if (i_byte == 8'd0) begin
                    if (r_err == V_ACCEPT) begin
                        w_err = V_ZERO_LEN;
                    end
                    w_phase = PH_DRAIN;
                end else if (r_lla) begin
                    if (r_seen) begin
                        if (r_err == V_ACCEPT) begin
                            w_err = V_DUPLICATE;
                        end
                        w_phase = PH_DRAIN;
                    end else if (i_byte != 8'd1) begin
                        if (r_err == V_ACCEPT) begin
                            w_err = V_SIZE;
                        end
                        w_phase = PH_DRAIN;
                    end else begin
                        w_rem   = LLA_BYTES;
                        w_mac   = '0;
                        w_phase = PH_LLA;
                    end
                end else begin
                    // option length in 8-byte units, type and length already taken
                    w_rem   = {i_byte, 3'b000} - 11'd2;
                    w_phase = PH_SKIP;
                end
            end
            PH_LLA: begin
                w_mac = {r_mac[MacW-9:0], i_byte};
                w_rem = w_dec;
                if (w_dec == 11'd0) begin
                    w_seen  = 1'b1;
                    w_phase = PH_OPT_TYPE;
                end
            end
            PH_SKIP: begin
                w_rem = w_dec;
                if (w_dec == 11'd0) begin
                    w_phase = PH_OPT_TYPE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (w_phase == PH_HEADER) begin
            w_verdict = V_SHORT;
        end else if (w_err != V_ACCEPT) begin
            w_verdict = w_err;
        end else if (w_phase == PH_LLA) begin
            w_verdict = V_SIZE;
        end else if (w_phase == PH_SKIP) begin
            w_verdict = V_TRUNC;
        end else if (w_unspec && !w_seen) begin
            w_verdict = V_UNIDENT;
        end else begin
            w_verdict = V_ACCEPT;
        end
    end

    assign o_result.verdict     = w_verdict;
    assign o_result.mac_present = w_seen;
    assign o_result.mac         = w_seen ? w_mac : '0;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_lla    = r_lla;
        n_seen   = r_seen;
        n_mac    = r_mac;
        n_err    = r_err;
        n_unspec = r_unspec;
        if (i_take) begin
            if (i_last) begin
                // message done, back to a fresh parse
                n_phase  = PH_HEADER;
                n_cnt    = 3'd0;
                n_rem    = 11'd0;
                n_lla    = 1'b0;
                n_seen   = 1'b0;
                n_mac    = '0;
                n_err    = V_ACCEPT;
                n_unspec = 1'b0;
            end else begin
                n_phase  = w_phase;
                n_cnt    = w_cnt;
                n_rem    = w_rem;
                n_lla    = w_lla;
                n_seen   = w_seen;
                n_mac    = w_mac;
                n_err    = w_err;
                n_unspec = w_unspec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_cnt    <= 3'd0;
            r_rem    <= 11'd0;
            r_lla    <= 1'b0;
            r_seen   <= 1'b0;
            r_mac    <= '0;
            r_err    <= V_ACCEPT;
            r_unspec <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_rem    <= n_rem;
            r_lla    <= n_lla;
            r_seen   <= n_seen;
            r_mac    <= n_mac;
            r_err    <= n_err;
            r_unspec <= n_unspec;
        end
    end

endmodule

`default_nettype wire

// ===== design/router_solicitation_checker_unit.sv =====
// ----------------------------------------------------------------------------
// router_solicitation_checker_unit
// Validates an ICMPv6 router solicitation one byte per cycle and reports
// one verdict plus the source link-layer address per message.
// ----------------------------------------------------------------------------
// a last byte accepted passes the input stage register and its result is then captured
// in the output register; throughput: one byte per cycle, the parse state updating
// once per byte taken; a result waiting on o_out_valid stalls input only when a
// last byte needs the output register
// reset (synchronous, active low) clears the parse state, the pipeline valids
// and the skip-check register
`default_nettype none

module router_solicitation_checker_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_sender_unspecified,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_verdict,
    output logic             o_source_mac_present,
    output logic [47:0]      o_source_mac,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rsc_pkg::*;

    logic       r_skip_check;
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_s1_unspec;
    logic       r_out_valid;
    t_result    r_res;
    t_result    w_res;
    logic       w_out_free;
    logic       w_s1_fire;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SKIP_CHECK) ? {31'd0, r_skip_check} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_check <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_SKIP_CHECK) begin
            r_skip_check <= pwdata[0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    // only a last byte needs room in the output register
    assign w_s1_fire  = r_s1_valid && (!r_s1_last || w_out_free);
    assign o_in_ready = !r_s1_valid || w_s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_byte   <= i_data_byte;
            r_s1_last   <= i_last_byte;
            r_s1_unspec <= i_sender_unspecified;
        end
    end

    rsc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_s1_fire),
        .i_byte       (r_s1_byte),
        .i_last       (r_s1_last),
        .i_unspec     (r_s1_unspec),
        .i_skip_check (r_skip_check),
        .o_result     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_last) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_verdict            = r_res.verdict;
    assign o_source_mac_present = r_res.mac_present;
    assign o_source_mac         = r_res.mac;

endmodule

`default_nettype wire

// ===== tb/router_solicitation_checker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// router_solicitation_checker_unit_tb
// Feeds ICMPv6 messages byte by byte into the checker and compares each
// verdict and captured source MAC against a cycle-free parser kept here.
// Directed messages hit the corner verdicts, random messages (mostly
// well-formed, some broken) run under both skip-check settings, with random
// idling on both sides, a long output stall and no-idle stretches.
// ----------------------------------------------------------------------------
module router_solicitation_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    typedef logic [7:0] t_byte_queue[$];

    localparam int          SETTLE_CYCLES = 6;
    localparam int          LONG_HOLD     = 300;
    localparam int          IDLE_LIMIT    = 2000;
    localparam logic [3:0]  NO_ERROR      = V_ACCEPT;
    localparam logic [2:0]  SKIP_ADDR     = {REG_SKIP_CHECK, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        i_sender_unspecified;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_verdict;
    logic        o_source_mac_present;
    logic [47:0] o_source_mac;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    router_solicitation_checker_unit i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // parser state mirrored from the block
    t_phase          sol_phase;
    logic [3:0]      sol_hdr_count;
    logic [10:0]     sol_remaining;
    logic            sol_is_lla;
    logic            sol_mac_seen;
    logic [MacW-1:0] sol_mac;
    logic [3:0]      sol_error;
    logic            sol_unspec;
    logic            skip_check_cfg;

    t_result pending_verdicts[$];

    int  mismatch_count = 0;
    int  bytes_sent     = 0;
    int  results_seen   = 0;
    int  idle_cycles    = 0;
    int  verdict_tally[9];
    bit  no_gaps        = 1'b0;
    bit  hold_request   = 1'b0;

    task automatic clear_solicit_state();
        sol_phase     = PH_HEADER;
        sol_hdr_count = '0;
        sol_remaining = '0;
        sol_is_lla    = 1'b0;
        sol_mac_seen  = 1'b0;
        sol_mac       = '0;
        sol_error     = NO_ERROR;
        sol_unspec    = 1'b0;
    endtask

    task automatic flag_parse_error(input logic [3:0] code);
        if (sol_error == NO_ERROR) sol_error = code;
        sol_phase = PH_DRAIN;
    endtask

    // advances the parser by one byte and queues a verdict on the last one
    task automatic parse_solicit_byte(input logic [7:0] b, input logic last,
                                      input logic unspec);
        t_result res;
        case (sol_phase)
            PH_HEADER: begin
                if (sol_hdr_count == 4'd0) begin
                    sol_unspec = unspec;
                    if (!skip_check_cfg && b != SOLICIT_TYPE) sol_error = V_TYPE;
                end else if (sol_hdr_count == 4'd1) begin
                    // code error overrides a type error
                    if (!skip_check_cfg && b != 8'd0) sol_error = V_CODE;
                end
                if (sol_hdr_count >= 4'd7) begin
                    sol_hdr_count = 4'd7;
                    sol_phase = (sol_error != NO_ERROR) ? PH_DRAIN : PH_OPT_TYPE;
                end else begin
                    sol_hdr_count++;
                end
            end
            PH_OPT_TYPE: begin
                sol_is_lla = (b == OPT_SRC_LLA);
                sol_phase  = PH_OPT_LEN;
            end
            PH_OPT_LEN: begin
                if (b == 8'd0) begin
                    flag_parse_error(V_ZERO_LEN);
                end else if (sol_is_lla) begin
                    if (sol_mac_seen) flag_parse_error(V_DUPLICATE);
                    else if (b != 8'd1) flag_parse_error(V_SIZE);
                    else begin
                        sol_remaining = LLA_BYTES;
                        sol_mac       = '0;
                        sol_phase     = PH_LLA;
                    end
                end else begin
                    // length counts 8-byte units including type and length
                    sol_remaining = {b, 3'b000} - 11'd2;
                    sol_phase     = PH_SKIP;
                end
            end
            PH_LLA: begin
                sol_mac = {sol_mac[MacW-9:0], b};
                if (sol_remaining != '0) sol_remaining--;
                if (sol_remaining == '0) begin
                    sol_mac_seen = 1'b1;
                    sol_phase    = PH_OPT_TYPE;
                end
            end
            PH_SKIP: begin
                if (sol_remaining != '0) sol_remaining--;
                if (sol_remaining == '0) sol_phase = PH_OPT_TYPE;
            end
            default: ;
        endcase
        if (last) begin
            if (sol_phase == PH_HEADER)          res.verdict = V_SHORT;
            else if (sol_error != NO_ERROR)      res.verdict = sol_error;
            else if (sol_phase == PH_LLA)        res.verdict = V_SIZE;
            else if (sol_phase == PH_SKIP)       res.verdict = V_TRUNC;
            else if (sol_unspec && !sol_mac_seen) res.verdict = V_UNIDENT;
            else                                 res.verdict = V_ACCEPT;
            res.mac_present = sol_mac_seen;
            res.mac         = sol_mac_seen ? sol_mac : '0;
            pending_verdicts.push_back(res);
            clear_solicit_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic unspec);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_data_byte          <= b;
        i_last_byte          <= last;
        i_sender_unspecified <= unspec;
        do @(posedge i_clk); while (!o_in_ready);
        parse_solicit_byte(b, last, unspec);
        bytes_sent++;
    endtask

    task automatic send_message(input t_byte_queue msg, input logic unspec);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1, (i == 0) ? unspec : 1'($urandom));
    endtask

    // input goes quiet, all verdicts drain, then the pipeline settles
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_skip_check(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SKIP_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        skip_check_cfg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value)) begin
            $display("%0t: skip-check readback mismatch, expected %0h, got %0h",
                     $time, 32'(value), prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_byte_queue solicit_header();
        t_byte_queue h;
        h = {SOLICIT_TYPE, 8'd0};
        repeat (6) h.push_back(8'($urandom));
        return h;
    endfunction

    function automatic void build_random_message(ref t_byte_queue msg);
        int         n_opts, lla_slot, len, mutation, cut;
        logic [7:0] kind;
        msg.delete();
        if (skip_check_cfg && $urandom_range(0, 1) == 1) begin
            msg = {8'($urandom), 8'($urandom)};
            repeat (6) msg.push_back(8'($urandom));
        end else if ($urandom_range(0, 99) < 8) begin
            msg = {($urandom_range(0, 1) == 1) ? 8'($urandom) : SOLICIT_TYPE,
                   ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'd0};
            repeat (6) msg.push_back(8'($urandom));
        end else begin
            msg = solicit_header();
        end
        n_opts   = $urandom_range(0, 3);
        lla_slot = $urandom_range(0, n_opts);
        for (int o = 0; o < n_opts; o++) begin
            if (o == lla_slot) begin
                msg = {msg, OPT_SRC_LLA, 8'd1};
                repeat (6) msg.push_back(8'($urandom));
            end else begin
                kind = 8'($urandom);
                if (kind == OPT_SRC_LLA) kind = 8'd3;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 16)
                                                  : $urandom_range(1, 3);
                msg = {msg, kind, 8'(len)};
                repeat (8 * len - 2) msg.push_back(8'($urandom));
            end
        end
        mutation = $urandom_range(0, 99);
        if (mutation < 10) begin
            msg.push_back(8'($urandom));
        end else if (mutation < 16) begin
            cut = $urandom_range(1, msg.size());
            msg = msg[0:cut-1];
        end else if (mutation < 20) begin
            msg = {msg, 8'($urandom), 8'd0};
            repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom));
        end else if (mutation < 25) begin
            // a second source option, or the first one if none came yet
            msg = {msg, OPT_SRC_LLA, 8'd1};
            repeat (6) msg.push_back(8'($urandom));
        end else if (mutation < 29) begin
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 255);
            msg = {msg, OPT_SRC_LLA, 8'(len)};
            repeat ($urandom_range(0, 8)) msg.push_back(8'($urandom));
        end else if (mutation < 33) begin
            kind = 8'($urandom_range(2, 255));
            msg  = {msg, kind, 8'($urandom_range(17, 255))};
            repeat ($urandom_range(0, 30)) msg.push_back(8'($urandom));
        end else if (mutation < 36) begin
            msg.delete();
            repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom));
        end
    endfunction

    task automatic test_short_message();
        // type and code are wrong too, the short verdict still wins
        send_message({8'h00, 8'hFF, 8'h7F}, 1'b1);
    endtask

    task automatic test_code_over_type();
        send_message({8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80}, 1'b0);
    endtask

    task automatic test_register_change_mid_message();
        t_byte_queue rest;
        wait_until_idle();
        write_skip_check(1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        wait_until_idle();
        write_skip_check(1'b0);
        rest = {8'h00, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00,
                OPT_SRC_LLA, 8'd1, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80};
        foreach (rest[i]) send_byte(rest[i], i == rest.size() - 1, 1'b0);
    endtask

    task automatic test_source_option_errors();
        t_byte_queue msg;
        // duplicate source option; the later zero length is drained
        msg = solicit_header();
        msg = {msg, OPT_SRC_LLA, 8'd1, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFE,
               OPT_SRC_LLA, 8'd1, 8'd0, 8'd0};
        send_message(msg, 1'b0);
        msg = solicit_header();
        msg = {msg, 8'd7, 8'd0, 8'd1};
        send_message(msg, 1'b0);
        msg = solicit_header();
        msg = {msg, OPT_SRC_LLA, 8'd2, 8'hAA};
        send_message(msg, 1'b1);
    endtask

    task automatic test_truncated_options();
        t_byte_queue msg;
        msg = solicit_header();
        msg = {msg, OPT_SRC_LLA, 8'd1, 8'h01, 8'h02, 8'h03};
        send_message(msg, 1'b0);
        msg = solicit_header();
        msg = {msg, 8'd2, 8'd255, 8'h55, 8'hAA};
        send_message(msg, 1'b0);
    endtask

    task automatic test_trailing_byte_unidentified();
        t_byte_queue msg;
        msg = solicit_header();
        msg = {msg, 8'd3, 8'd1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'd9};
        send_message(msg, 1'b1);
    endtask

    task automatic test_random_traffic(input logic skip, input int budget, input bit steady);
        t_byte_queue msg;
        int          stop_at;
        wait_until_idle();
        write_skip_check(skip);
        no_gaps = steady;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            build_random_message(msg);
            send_message(msg, 1'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        t_byte_queue msg;
        wait_until_idle();
        hold_request = 1'b1;
        no_gaps      = 1'b1;
        repeat (30) begin
            msg.delete();
            repeat ($urandom_range(1, 2)) msg.push_back(8'($urandom));
            send_message(msg, 1'($urandom));
        end
        no_gaps = 1'b0;
        // sender stays quiet until every verdict is out
        wait_until_idle();
    endtask

    // result side: per-item stall, plus one long hold on request
    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 3);
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk);
            while (!(o_out_valid && i_out_ready) && !hold_request);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, verdict %0d mac %012h",
                         $time, o_verdict, o_source_mac);
                mismatch_count++;
            end else begin
                exp = pending_verdicts.pop_front();
                verdict_tally[exp.verdict]++;
                if (o_verdict !== exp.verdict) begin
                    $display("%0t: verdict mismatch, expected %0d, got %0d",
                             $time, exp.verdict, o_verdict);
                    mismatch_count++;
                end
                if (o_source_mac_present !== exp.mac_present) begin
                    $display("%0t: mac_present mismatch, expected %0b, got %0b",
                             $time, exp.mac_present, o_source_mac_present);
                    mismatch_count++;
                end
                if (o_source_mac !== exp.mac) begin
                    $display("%0t: source_mac mismatch, expected %012h, got %012h",
                             $time, exp.mac, o_source_mac);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        i_in_valid           <= 1'b0;
        i_data_byte          <= 8'd0;
        i_last_byte          <= 1'b0;
        i_sender_unspecified <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        skip_check_cfg = 1'b0;
        clear_solicit_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_skip_check(1'b0);
        test_short_message();
        test_code_over_type();
        test_register_change_mid_message();
        test_source_option_errors();
        test_truncated_options();
        test_trailing_byte_unidentified();
        test_random_traffic(1'b0, 650, 1'b0);
        test_output_backpressure();
        test_random_traffic(1'b1, 450, 1'b0);
        test_random_traffic(1'b0, 400, 1'b1);
        test_random_traffic(1'b1, 300, 1'b0);
        wait_until_idle();

        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
            mismatch_count++;
        end
        $display("run: %0d bytes, %0d verdicts checked, skip-check 0 and 1, long output hold",
                 bytes_sent, results_seen);
        $display("verdict mix acc/short/code/type/zlen/dup/size/trunc/unid: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4], verdict_tally[5], verdict_tally[6], verdict_tally[7],
                 verdict_tally[8]);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== router_solicitation_checker_unit.f =====
design/rsc_pkg.sv
design/rsc_parser.sv
design/router_solicitation_checker_unit.sv
tb/router_solicitation_checker_unit_tb.sv
